// ===== rtl/core/btb_pkg.sv =====
package btb_pkg;

    // Default coordinate width: signed Q16.16.
    localparam int COORD_WIDTH_DEF = 32;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Dividend bits that one divider stage retires.
    localparam int DIV_STEP = 8;

    // Index of the closing window of a path (four windows per last point).
    localparam logic [1:0] LAST_WINDOW = 2'd3;

    typedef enum logic [1:0] {
        ROLE_FIRST_HANDLE  = 2'd0,
        ROLE_SECOND_HANDLE = 2'd1,
        ROLE_JOIN          = 2'd2
    } role_t;

    // Side information that travels with each result through the divider.
    typedef struct packed {
        role_t role;
        logic  curve_end;
    } tag_t;

endpackage

// ===== rtl/core/btb_front.sv =====
module btb_front #(
    parameter int COORD_WIDTH = btb_pkg::COORD_WIDTH_DEF,
    localparam int ENTRY_W = 6 * COORD_WIDTH + 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic                          last_point,
    input  logic                          queue_full,
    output logic                          push,
    output logic [ENTRY_W-1:0]            entry
);

    logic [COORD_WIDTH-1:0] older_x_reg;
    logic [COORD_WIDTH-1:0] older_y_reg;
    logic [COORD_WIDTH-1:0] newer_x_reg;
    logic [COORD_WIDTH-1:0] newer_y_reg;
    logic                   started_reg;

    logic [COORD_WIDTH-1:0] a_x;
    logic [COORD_WIDTH-1:0] a_y;
    logic [COORD_WIDTH-1:0] b_x;
    logic [COORD_WIDTH-1:0] b_y;

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    // The first point of a path stands in for the whole window.
    always_comb begin
        if (started_reg) begin
            a_x = older_x_reg;
            a_y = older_y_reg;
            b_x = newer_x_reg;
            b_y = newer_y_reg;
        end else begin
            a_x = point_x;
            a_y = point_y;
            b_x = point_x;
            b_y = point_y;
        end
    end

    assign entry = {a_x, a_y, b_x, b_y, point_x, point_y, last_point};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            older_x_reg <= '0;
            older_y_reg <= '0;
            newer_x_reg <= '0;
            newer_y_reg <= '0;
            started_reg <= 1'b0;
        end else if (push) begin
            older_x_reg <= b_x;
            older_y_reg <= b_y;
            newer_x_reg <= point_x;
            newer_y_reg <= point_y;
            started_reg <= !last_point;
        end
    end

endmodule

// ===== rtl/core/btb_queue.sv =====
module btb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = btb_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = data_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/btb_div3.sv =====
module btb_div3 #(
    parameter int COORD_WIDTH = btb_pkg::COORD_WIDTH_DEF,
    localparam int UW     = COORD_WIDTH + 3,
    localparam int STAGES = (UW + btb_pkg::DIV_STEP - 1) / btb_pkg::DIV_STEP,
    localparam int PADW   = STAGES * btb_pkg::DIV_STEP
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [UW-1:0]          in_ux,
    input  logic [UW-1:0]          in_uy,
    input  btb_pkg::tag_t          in_tag,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_WIDTH-1:0] out_qx,
    output logic [COORD_WIDTH-1:0] out_qy,
    output btb_pkg::tag_t          out_tag
);

    // Each stage runs restoring long division by three over DIV_STEP bits,
    // most significant first. Quotient bits replace the dividend bits in place.
    logic [PADW-1:0]     work_reg [STAGES][2];
    logic [1:0]          rem_reg  [STAGES][2];
    btb_pkg::tag_t       tag_reg  [STAGES];
    logic [STAGES-1:0]   valid_reg;

    logic [PADW-1:0]     work_in  [STAGES][2];
    logic [1:0]          rem_in   [STAGES][2];
    logic [PADW-1:0]     work_out [STAGES][2];
    logic [1:0]          rem_out  [STAGES][2];
    btb_pkg::tag_t       tag_in   [STAGES];
    logic [STAGES-1:0]   valid_in;
    logic [STAGES:0]     rdy;

    assign rdy[STAGES] = out_ready;
    assign in_ready    = rdy[0];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam int BASE = PADW - 1 - s * btb_pkg::DIV_STEP;

        assign rdy[s] = !valid_reg[s] || rdy[s+1];

        if (s == 0) begin : g_first
            assign work_in[0][0] = PADW'(in_ux);
            assign work_in[0][1] = PADW'(in_uy);
            assign rem_in[0][0]  = '0;
            assign rem_in[0][1]  = '0;
            assign tag_in[0]     = in_tag;
            assign valid_in[0]   = in_valid;
        end else begin : g_later
            assign work_in[s][0] = work_reg[s-1][0];
            assign work_in[s][1] = work_reg[s-1][1];
            assign rem_in[s][0]  = rem_reg[s-1][0];
            assign rem_in[s][1]  = rem_reg[s-1][1];
            assign tag_in[s]     = tag_reg[s-1];
            assign valid_in[s]   = valid_reg[s-1];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            always_comb begin
                logic [PADW-1:0] w;
                logic [1:0]      r;
                logic [2:0]      t;
                logic            q;
                w = work_in[s][l];
                r = rem_in[s][l];
                for (int i = 0; i < btb_pkg::DIV_STEP; i++) begin
                    t = {r, w[BASE-i]};
                    q = (t >= 3'd3);
                    r = q ? 2'(t - 3'd3) : t[1:0];
                    w[BASE-i] = q;
                end
                work_out[s][l] = w;
                rem_out[s][l]  = r;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int s = 0; s < STAGES; s++) begin
                if (rdy[s]) begin
                    valid_reg[s] <= valid_in[s];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < STAGES; s++) begin
            if (rdy[s] && valid_in[s]) begin
                work_reg[s][0] <= work_out[s][0];
                work_reg[s][1] <= work_out[s][1];
                rem_reg[s][0]  <= rem_out[s][0];
                rem_reg[s][1]  <= rem_out[s][1];
                tag_reg[s]     <= tag_in[s];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_qx    = work_reg[STAGES-1][0][COORD_WIDTH-1:0];
    assign out_qy    = work_reg[STAGES-1][1][COORD_WIDTH-1:0];
    assign out_tag   = tag_reg[STAGES-1];

endmodule

// ===== rtl/core/btb_back.sv =====
module btb_back #(
    parameter int COORD_WIDTH = btb_pkg::COORD_WIDTH_DEF,
    localparam int ENTRY_W = 6 * COORD_WIDTH + 1,
    localparam int NW = COORD_WIDTH + 3,
    localparam int MW = COORD_WIDTH + 2,
    localparam int UW = COORD_WIDTH + 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   head_valid,
    input  logic [ENTRY_W-1:0]     head_data,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COORD_WIDTH-1:0] out_x,
    output logic [COORD_WIDTH-1:0] out_y,
    output btb_pkg::tag_t          out_tag
);

    localparam int W = COORD_WIDTH;

    logic [W-1:0] e_ax, e_ay, e_bx, e_by, e_cx, e_cy;
    logic         e_last;

    assign {e_ax, e_ay, e_bx, e_by, e_cx, e_cy, e_last} = head_data;

    // Sequencer: walks the windows of one entry, one result per cycle while the dividend stage can take it.
    logic [1:0]            win_reg;
    btb_pkg::role_t        role_reg;
    logic                  seq_valid_reg;
    logic signed [NW-1:0]  seq_nx_reg;
    logic signed [NW-1:0]  seq_ny_reg;
    btb_pkg::tag_t         seq_tag_reg;

    logic                  prep_valid_reg;
    logic [UW-1:0]         prep_ux_reg;
    logic [UW-1:0]         prep_uy_reg;
    btb_pkg::tag_t         prep_tag_reg;

    logic                  div_ready;
    logic                  prep_ready;
    logic                  seq_ready;
    logic                  seq_adv;
    logic                  item_done;
    logic [W-1:0]          sa_x, sa_y, sb_x, sb_y, sc_x, sc_y;
    btb_pkg::tag_t         seq_tag;

    function automatic logic signed [NW-1:0] weighted_sum(
        input btb_pkg::role_t r,
        input logic [W-1:0]   a,
        input logic [W-1:0]   b,
        input logic [W-1:0]   c
    );
        logic signed [NW-1:0] ea;
        logic signed [NW-1:0] eb;
        logic signed [NW-1:0] ec;
        ea = $signed({{3{a[W-1]}}, a});
        eb = $signed({{3{b[W-1]}}, b});
        ec = $signed({{3{c[W-1]}}, c});
        unique case (r)
            btb_pkg::ROLE_FIRST_HANDLE:  return (ea <<< 1) + eb;
            btb_pkg::ROLE_SECOND_HANDLE: return ea + (eb <<< 1);
            btb_pkg::ROLE_JOIN:          return ea + (eb <<< 2) + ec;
            default:                     return '0;
        endcase
    endfunction

    // Rounded division becomes floor((n+1)/3) for handles and
    // floor(((n+3)>>1)/3) for the join point. The signed dividend is then
    // offset by 3*2^(MW-1), which is free, and drops out of the low bits.
    function automatic logic [UW-1:0] biased_dividend(
        input btb_pkg::role_t       r,
        input logic signed [NW-1:0] n
    );
        logic [NW-1:0] plus_one;
        logic [NW-1:0] plus_three;
        logic [MW-1:0] m;
        plus_one   = n + NW'(1);
        plus_three = n + NW'(3);
        if (r == btb_pkg::ROLE_JOIN) begin
            m = plus_three[NW-1:1];
        end else begin
            m = plus_one[MW-1:0];
        end
        return {1'b1, ~m[MW-1], m[MW-2:0]};
    endfunction

    always_comb begin
        unique case (win_reg)
            2'd0: begin
                sa_x = e_ax; sa_y = e_ay;
                sb_x = e_bx; sb_y = e_by;
            end
            2'd1: begin
                sa_x = e_bx; sa_y = e_by;
                sb_x = e_cx; sb_y = e_cy;
            end
            default: begin
                sa_x = e_cx; sa_y = e_cy;
                sb_x = e_cx; sb_y = e_cy;
            end
        endcase
        sc_x = e_cx;
        sc_y = e_cy;
    end

    assign seq_tag.role      = role_reg;
    assign seq_tag.curve_end = e_last && (win_reg == btb_pkg::LAST_WINDOW)
                               && (role_reg == btb_pkg::ROLE_JOIN);

    assign prep_ready = !prep_valid_reg || div_ready;
    assign seq_ready  = !seq_valid_reg || prep_ready;
    assign seq_adv    = head_valid && seq_ready;
    assign item_done  = (role_reg == btb_pkg::ROLE_JOIN)
                        && (!e_last || (win_reg == btb_pkg::LAST_WINDOW));
    assign pop        = seq_adv && item_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg        <= '0;
            role_reg       <= btb_pkg::ROLE_FIRST_HANDLE;
            seq_valid_reg  <= 1'b0;
            prep_valid_reg <= 1'b0;
        end else begin
            if (seq_adv) begin
                unique case (role_reg)
                    btb_pkg::ROLE_FIRST_HANDLE:  role_reg <= btb_pkg::ROLE_SECOND_HANDLE;
                    btb_pkg::ROLE_SECOND_HANDLE: role_reg <= btb_pkg::ROLE_JOIN;
                    default:                     role_reg <= btb_pkg::ROLE_FIRST_HANDLE;
                endcase
                if (item_done) begin
                    win_reg <= '0;
                end else if (role_reg == btb_pkg::ROLE_JOIN) begin
                    win_reg <= win_reg + 1'b1;
                end
            end
            if (seq_ready) begin
                seq_valid_reg <= head_valid;
            end
            if (prep_ready) begin
                prep_valid_reg <= seq_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_adv) begin
            seq_nx_reg  <= weighted_sum(role_reg, sa_x, sb_x, sc_x);
            seq_ny_reg  <= weighted_sum(role_reg, sa_y, sb_y, sc_y);
            seq_tag_reg <= seq_tag;
        end
        if (prep_ready && seq_valid_reg) begin
            prep_ux_reg  <= biased_dividend(seq_tag_reg.role, seq_nx_reg);
            prep_uy_reg  <= biased_dividend(seq_tag_reg.role, seq_ny_reg);
            prep_tag_reg <= seq_tag_reg;
        end
    end

    btb_div3 #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_div3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid_reg),
        .in_ready  (div_ready),
        .in_ux     (prep_ux_reg),
        .in_uy     (prep_uy_reg),
        .in_tag    (prep_tag_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_qx    (out_x),
        .out_qy    (out_y),
        .out_tag   (out_tag)
    );

endmodule

// ===== rtl/core/bspline_to_bezier_points.sv =====
// Uniform cubic B-spline to cubic Bezier converter. Control points arrive as
// signed fixed-point x,y pairs; last_point marks the end of a path. Each
// control point produces three Bezier points (first handle, second handle,
// segment join), and a point marked last produces twelve, the final one
// flagged with curve_end. The first and last points of a path are treated as
// tripled. All results are rounded to nearest with halves toward plus
// infinity and always fit the coordinate width. Results leave at one per
// cycle while m_ready is held; that rate is set by the back-end sequencer,
// which issues one result into the divider pipeline per cycle unless the
// pipeline ahead stalls. Input is accepted whenever the two-entry queue
// behind the front end has room, so the front keeps taking points while
// earlier ones are still being expanded. From an input transfer to its
// first result transfer, the data passes the queue, the sequencer register,
// the dividend register and ceil((COORD_WIDTH+3)/8) divide-by-three
// stages.
module bspline_to_bezier_points #(
    parameter int COORD_WIDTH = btb_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_point_x,
    input  logic signed [COORD_WIDTH-1:0] s_point_y,
    input  logic                          s_last_point,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_out_x,
    output logic signed [COORD_WIDTH-1:0] m_out_y,
    output logic [1:0]                    m_point_role,
    output logic                          m_curve_end
);

    localparam int ENTRY_W = 6 * COORD_WIDTH + 1;

    // A queue entry is one full window triple (a, b, c) plus the last flag;
    // the back end derives the trailing windows of a path from it.
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_head_valid;
    logic [ENTRY_W-1:0] q_push_data;
    logic [ENTRY_W-1:0] q_head_data;

    logic [COORD_WIDTH-1:0] res_x;
    logic [COORD_WIDTH-1:0] res_y;
    btb_pkg::tag_t          res_tag;

    btb_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .point_x    (s_point_x),
        .point_y    (s_point_y),
        .last_point (s_last_point),
        .queue_full (q_full),
        .push       (q_push),
        .entry      (q_push_data)
    );

    btb_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(btb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data)
    );

    btb_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .out_x      (res_x),
        .out_y      (res_y),
        .out_tag    (res_tag)
    );

    assign m_out_x      = $signed(res_x);
    assign m_out_y      = $signed(res_y);
    assign m_point_role = res_tag.role;
    assign m_curve_end  = res_tag.curve_end;

    // The end-of-curve flag can only ride on a segment join point.
    a_end_on_join: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_curve_end |-> m_point_role == btb_pkg::ROLE_JOIN)
        else $error("curve_end set on a handle point");

    // The back end only takes an entry that the queue actually holds.
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_head_valid)
        else $error("queue popped while empty");

    // Nothing is presented in the cycle right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule
